FILE: rtl/multi_slot_software_timer_bank_core_assert.svh
// Assertion macros shared by the timer bank checkers.
`ifndef MULTI_SLOT_SOFTWARE_TIMER_BANK_CORE_ASSERT_SVH
`define MULTI_SLOT_SOFTWARE_TIMER_BANK_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer bank assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer bank assertion failed");

`endif

FILE: rtl/mst_pkg.sv
// Types and constants shared by the timer bank modules.
`default_nettype none

package mst_pkg;

    localparam int DUR_W       = 32;
    localparam int REP_W       = 17;
    localparam int SLOT_W      = 4;
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_CNT_W  = 5;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_ADD_ONE = 2'd1,
        MODE_ADD_REP = 2'd2,
        MODE_CLEAR   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_FIRED    = 2'd0,
        KIND_ADDED    = 2'd1,
        KIND_REJECTED = 2'd2,
        KIND_CLEARED  = 2'd3
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic idx_inc;
        logic mem_rd;
        logic tick_upd;
        logic add_wr;
        logic emit_reject;
        logic clear_all;
        logic flush;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_active;
        logic idx_last;
        logic out_free;
        logic fire_due;
        logic pend_valid;
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/mst_req_if.sv
// Request channel interface of the timer bank.
`default_nettype none

interface mst_req_if;
    import mst_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               mode;
    logic [DUR_W-1:0]         duration;
    logic signed [REP_W-1:0]  repeat_count;

    modport source (output valid, mode, duration, repeat_count, input ready);
    modport sink (input valid, mode, duration, repeat_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/mst_rsp_if.sv
// Result channel interface of the timer bank.
`default_nettype none

interface mst_rsp_if;
    import mst_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic              last;

    modport source (output valid, kind, slot, last, input ready);
    modport sink (input valid, kind, slot, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/mst_ctrl.sv
// Controller state machine that sequences add, clear and tick scans.
`default_nettype none

module mst_ctrl
    import mst_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    input  wire mode_t   req_mode,
    output logic         req_ready,
    input  wire status_t sts,
    output cmd_t         cmd
);

    typedef enum logic [5:0] {
        ST_IDLE       = 6'b000001,
        ST_ADD        = 6'b000010,
        ST_CLEAR      = 6'b000100,
        ST_TICK_RD    = 6'b001000,
        ST_TICK_UPD   = 6'b010000,
        ST_TICK_FLUSH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        req_ready  = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (req_mode) inside
                        MODE_TICK:                  state_next = ST_TICK_RD;
                        MODE_CLEAR:                 state_next = ST_CLEAR;
                        MODE_ADD_ONE, MODE_ADD_REP: state_next = ST_ADD;
                        default:                    state_next = ST_ADD;
                    endcase
                end
            end
            ST_ADD:
            begin
                if (!sts.slot_active)
                begin
                    if (sts.out_free)
                    begin
                        cmd.add_wr = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (sts.idx_last)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit_reject = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_CLEAR:
            begin
                if (sts.out_free)
                begin
                    cmd.clear_all = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_TICK_RD:
            begin
                if (sts.slot_active)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_TICK_UPD;
                end
                else if (sts.idx_last)
                begin
                    state_next = ST_TICK_FLUSH;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_TICK_UPD:
            begin
                // A new fire pushes the held one out, so it waits for the output register.
                if (!(sts.fire_due && sts.pend_valid && !sts.out_free))
                begin
                    cmd.tick_upd = 1'b1;
                    if (sts.idx_last)
                    begin
                        state_next = ST_TICK_FLUSH;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_TICK_RD;
                    end
                end
            end
            ST_TICK_FLUSH:
            begin
                if (!sts.pend_valid || sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/mst_datapath.sv
// Slot memory, active bits, shared tick update unit and result register.
`default_nettype none

module mst_datapath
    import mst_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output status_t                sts,
    input  wire mode_t             req_mode,
    input  wire logic [DUR_W-1:0]  req_duration,
    input  wire logic [REP_W-1:0]  req_repeat,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output kind_t                  out_kind,
    output logic [SLOT_W-1:0]      out_slot,
    output logic                   out_last
);

    localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int WORD_W = 2 * TIME_BITS + REP_W;
    localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(NUM_SLOTS - 1);
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    logic [NUM_SLOTS-1:0]  active_reg;
    logic [NUM_SLOTS-1:0]  active_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [TIME_BITS-1:0]  dur_reg;
    logic [REP_W-1:0]      rep_reg;
    logic [WORD_W-1:0]     mem [NUM_SLOTS];
    logic [WORD_W-1:0]     rd_word_reg;
    logic                  pend_valid_reg;
    logic [IDX_W-1:0]      pend_slot_reg;
    logic [FIRE_CNT_W-1:0] fire_cnt_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    kind_t                 out_kind_reg;
    kind_t                 out_kind_next;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [SLOT_W-1:0]     out_slot_next;
    logic                  out_last_reg;
    logic                  out_last_next;
    logic                  emit;

    logic [TIME_BITS-1:0]  rd_period;
    logic [TIME_BITS-1:0]  rd_elapsed;
    logic [REP_W-1:0]      rd_rep;
    logic [TIME_BITS-1:0]  el_inc;
    logic [REP_W-1:0]      rep_dec;
    logic                  rep_zero;
    logic                  rep_pos;
    logic                  fire_due;
    logic                  mem_we;
    logic [WORD_W-1:0]     mem_wdata;

    assign rd_period  = rd_word_reg[WORD_W-1 -: TIME_BITS];
    assign rd_elapsed = rd_word_reg[REP_W+TIME_BITS-1 -: TIME_BITS];
    assign rd_rep     = rd_word_reg[REP_W-1:0];

    // The elapsed count saturates, so a full period still compares as due.
    assign el_inc   = (rd_elapsed == TIME_MAX) ? rd_elapsed : rd_elapsed + TIME_BITS'(1);
    assign rep_zero = (rd_rep == '0);
    assign rep_pos  = !rd_rep[REP_W-1] && !rep_zero;
    assign rep_dec  = rep_pos ? rd_rep - REP_W'(1) : rd_rep;
    assign fire_due = !rep_zero && (el_inc >= rd_period)
                      && (fire_cnt_reg < FIRE_CNT_W'(MAX_RESULTS));

    assign sts.slot_active = active_reg[idx_reg];
    assign sts.idx_last    = (idx_reg == LAST_IDX);
    assign sts.out_free    = !out_valid_reg || out_ready;
    assign sts.fire_due    = fire_due;
    assign sts.pend_valid  = pend_valid_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = {rd_period, el_inc, rd_rep};
        if (cmd.add_wr)
        begin
            mem_we    = 1'b1;
            mem_wdata = {dur_reg, TIME_BITS'(0), rep_reg};
        end
        else if (cmd.tick_upd && !rep_zero)
        begin
            mem_we = 1'b1;
            if (fire_due)
            begin
                mem_wdata = {rd_period, TIME_BITS'(0), rep_dec};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            rd_word_reg <= mem[idx_reg];
        end
    end

    always_comb
    begin
        active_next = active_reg;
        if (cmd.clear_all)
        begin
            active_next = '0;
        end
        if (cmd.add_wr)
        begin
            active_next[idx_reg] = 1'b1;
        end
        if (cmd.tick_upd)
        begin
            if (rep_zero || (fire_due && (rep_dec == '0)))
            begin
                active_next[idx_reg] = 1'b0;
            end
        end
    end

    // A fire is held until the next one or the end of the scan shows whether it is the last.
    always_comb
    begin
        emit          = 1'b0;
        out_kind_next = out_kind_reg;
        out_slot_next = out_slot_reg;
        out_last_next = out_last_reg;
        if (cmd.tick_upd && fire_due && pend_valid_reg)
        begin
            emit          = 1'b1;
            out_kind_next = KIND_FIRED;
            out_slot_next = SLOT_W'(pend_slot_reg);
            out_last_next = 1'b0;
        end
        else if (cmd.flush && pend_valid_reg)
        begin
            emit          = 1'b1;
            out_kind_next = KIND_FIRED;
            out_slot_next = SLOT_W'(pend_slot_reg);
            out_last_next = 1'b1;
        end
        else if (cmd.add_wr)
        begin
            emit          = 1'b1;
            out_kind_next = KIND_ADDED;
            out_slot_next = SLOT_W'(idx_reg);
            out_last_next = 1'b1;
        end
        else if (cmd.emit_reject)
        begin
            emit          = 1'b1;
            out_kind_next = KIND_REJECTED;
            out_slot_next = '0;
            out_last_next = 1'b1;
        end
        else if (cmd.clear_all)
        begin
            emit          = 1'b1;
            out_kind_next = KIND_CLEARED;
            out_slot_next = '0;
            out_last_next = 1'b1;
        end
        out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            fire_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            if (cmd.load)
            begin
                idx_reg        <= '0;
                pend_valid_reg <= 1'b0;
                fire_cnt_reg   <= '0;
            end
            else
            begin
                if (cmd.idx_inc)
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                if (cmd.tick_upd && fire_due)
                begin
                    pend_valid_reg <= 1'b1;
                    fire_cnt_reg   <= fire_cnt_reg + FIRE_CNT_W'(1);
                end
                else if (cmd.flush)
                begin
                    pend_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dur_reg <= TIME_BITS'(req_duration);
            rep_reg <= (req_mode == MODE_ADD_ONE) ? REP_W'(1) : req_repeat;
        end
        if (cmd.tick_upd && fire_due)
        begin
            pend_slot_reg <= idx_reg;
        end
        out_kind_reg <= out_kind_next;
        out_slot_reg <= out_slot_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_slot  = out_slot_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/multi_slot_software_timer_bank_core.sv
// Top level of the multi-slot timer bank: controller plus slot datapath.
`default_nettype none

// A bank of NUM_SLOTS timer slots. An add item takes the lowest free slot and
// answers with its number, or with a rejection when the bank is full; a clear
// item frees every slot and answers once; a tick item advances every active
// slot and reports the slots that fire, in ascending slot order, with last set
// on the final report (a tick that fires nothing reports nothing). One item is
// worked on at a time. Slot state sits in a single-ported memory with a
// registered read, and one shared update unit walks it: a tick reads and
// updates each active slot and steps past each free one, an add steps past
// each occupied slot below the free one (every slot when full), and each item
// stalls at its result while the result register waits to be taken.
// A new item is taken while a finished result still waits at the output.
module multi_slot_software_timer_bank_core
    import mst_pkg::*;
#(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 32
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mst_req_if.sink    request,
    mst_rsp_if.source  result
);

    cmd_t    cmd;
    status_t sts;
    kind_t   rsp_kind;

    mst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_mode  (mode_t'(request.mode)),
        .req_ready (request.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mst_datapath #(
        .NUM_SLOTS (NUM_SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_mode     (mode_t'(request.mode)),
        .req_duration (request.duration),
        .req_repeat   (request.repeat_count),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .out_kind     (rsp_kind),
        .out_slot     (result.slot),
        .out_last     (result.last)
    );

    assign result.kind = rsp_kind;

endmodule

`default_nettype wire

FILE: rtl/mst_checker.sv
// Port-level assertion checker for the timer bank, with its bind.
`default_nettype none

`include "multi_slot_software_timer_bank_core_assert.svh"

module mst_checker
    import mst_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire logic [1:0]        rsp_kind,
    input wire logic [SLOT_W-1:0] rsp_slot,
    input wire logic              rsp_last
);

    `MST_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `MST_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_kind) && $stable(rsp_slot) && $stable(rsp_last))
    // Rejections and clears carry no slot and always end their item.
    `MST_ASSERT_NOW(a_no_slot, clk, rst_n, rsp_valid && (rsp_kind == KIND_REJECTED || rsp_kind == KIND_CLEARED), (rsp_slot == '0) && rsp_last)
    // An add answers with exactly one result.
    `MST_ASSERT_NOW(a_add_last, clk, rst_n, rsp_valid && (rsp_kind == KIND_ADDED), rsp_last)

endmodule

bind multi_slot_software_timer_bank_core mst_checker u_mst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (result.valid),
    .rsp_ready (result.ready),
    .rsp_kind  (result.kind),
    .rsp_slot  (result.slot),
    .rsp_last  (result.last)
);

`default_nettype wire

FILE: sim/tb_timer_bank_monitor.sv
// Monitor for the timer bank channels: predicts slot reports and compares them.
`timescale 1ns / 1ps

module tb_timer_bank_monitor
    import mst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mst_req_if   request,
    mst_rsp_if   result,
    output int   fail_count,
    output int   pending_results
);

    localparam int SLOTS = 16;

    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } slot_report_t;

    // Shadow copy of the bank.
    bit                      slot_on   [SLOTS];
    logic [DUR_W-1:0]        slot_len  [SLOTS];
    logic [DUR_W-1:0]        slot_age  [SLOTS];
    logic signed [REP_W-1:0] slot_left [SLOTS];

    slot_report_t slot_reports[$];

    initial begin
        fail_count      = 0;
        pending_results = 0;
        foreach (slot_on[i])
            slot_on[i] = 1'b0;
    end

    // Work out the reports that one request causes and queue them.
    task automatic apply_request(input mode_t mode, input logic [DUR_W-1:0] dur,
                                 input logic signed [REP_W-1:0] reps);
        slot_report_t batch[$];
        slot_report_t r;
        int           free_idx;
        free_idx = -1;
        case (mode)
            MODE_TICK:
            begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!slot_on[i])
                        continue;
                    // A slot added with a zero count leaves quietly.
                    if (slot_left[i] == 0) begin
                        slot_on[i] = 1'b0;
                        continue;
                    end
                    if (slot_age[i] != '1)
                        slot_age[i]++;
                    if (slot_age[i] >= slot_len[i] && batch.size() < MAX_RESULTS) begin
                        r.kind = KIND_FIRED;
                        r.slot = SLOT_W'(i);
                        r.last = 1'b0;
                        batch = {batch, r};
                        slot_age[i] = '0;
                        if (slot_left[i] > 0)
                            slot_left[i]--;
                        if (slot_left[i] == 0)
                            slot_on[i] = 1'b0;
                    end
                end
            end
            MODE_CLEAR:
            begin
                foreach (slot_on[i])
                    slot_on[i] = 1'b0;
                r.kind = KIND_CLEARED;
                r.slot = '0;
                r.last = 1'b0;
                batch = {batch, r};
            end
            default:
            begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!slot_on[i]) begin
                        free_idx = i;
                        break;
                    end
                end
                r.last = 1'b0;
                if (free_idx < 0) begin
                    r.kind = KIND_REJECTED;
                    r.slot = '0;
                end
                else begin
                    slot_on[free_idx]   = 1'b1;
                    slot_len[free_idx]  = dur;
                    slot_age[free_idx]  = '0;
                    slot_left[free_idx] = (mode == MODE_ADD_ONE) ? REP_W'(1) : reps;
                    r.kind = KIND_ADDED;
                    r.slot = SLOT_W'(free_idx);
                end
                batch = {batch, r};
            end
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        slot_reports = {slot_reports, batch};
    endtask

    task automatic check_field(input string field, input logic [3:0] want,
                               input logic [3:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin
        slot_report_t want;
        if (rst_n) begin
            if (request.valid && request.ready)
                apply_request(mode_t'(request.mode), request.duration, request.repeat_count);
            if (result.valid && result.ready) begin
                if (slot_reports.size() == 0) begin
                    $display("%0t: unexpected report, expected none, actual kind %0d slot %0d last %0d",
                             $time, result.kind, result.slot, result.last);
                    fail_count++;
                end
                else begin
                    want = slot_reports.pop_front();
                    check_field("kind", 4'(want.kind), 4'(result.kind));
                    check_field("slot", want.slot, result.slot);
                    check_field("last", 4'(want.last), 4'(result.last));
                end
            end
            pending_results = slot_reports.size();
        end
    end

endmodule

FILE: sim/tb_multi_slot_software_timer_bank_core.sv
// Testbench top for the timer bank: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module tb_multi_slot_software_timer_bank_core;
    import mst_pkg::*;

    localparam int RANDOM_ITEMS = 194;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 300;

    logic clk = 1'b0;
    logic rst_n;
    int   cycles = 0;
    int   bank_fail_count;
    int   bank_pending;

    // Request-side settings; quiet_tail and hold_off_req are shared with the result process.
    bit   gaps_on;
    bit   quiet_tail;
    bit   hold_off_req;

    mst_req_if request_ch ();
    mst_rsp_if result_ch ();

    multi_slot_software_timer_bank_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch)
    );

    tb_timer_bank_monitor bank_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .request         (request_ch),
        .result          (result_ch),
        .fail_count      (bank_fail_count),
        .pending_results (bank_pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d reports outstanding", $time, bank_pending);
            $display("tb_multi_slot_software_timer_bank_core failed");
            $finish;
        end
    end

    // Offer one request item and return at the edge where it is accepted.
    task automatic offer_item(input mode_t mode, input logic [DUR_W-1:0] dur,
                              input logic signed [REP_W-1:0] reps);
        if (gaps_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
            request_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        request_ch.valid        <= 1'b1;
        request_ch.mode         <= mode;
        request_ch.duration     <= dur;
        request_ch.repeat_count <= reps;
        do
            @(posedge clk);
        while (!request_ch.ready);
    endtask

    // Result side: random stall bursts, calm stretches, and one long hold-off.
    initial begin
        int stall_left;
        int calm_left;
        int hold_left;
        stall_left = 0;
        calm_left  = 0;
        hold_left  = 0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else begin
                result_ch.ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if (!quiet_tail && $urandom_range(0, 4) == 0)
                    stall_left = $urandom_range(1, 7);
                else if ($urandom_range(0, 40) == 0)
                    calm_left = $urandom_range(20, 80);
            end
        end
    end

    initial begin
        mode_t                   m;
        logic [DUR_W-1:0]        dur;
        logic signed [REP_W-1:0] rep;
        int                      pick;
        gaps_on      = 1'b1;
        quiet_tail   = 1'b0;
        hold_off_req = 1'b0;
        rst_n                   <= 1'b0;
        request_ch.valid        <= 1'b0;
        request_ch.mode         <= MODE_TICK;
        request_ch.duration     <= '0;
        request_ch.repeat_count <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Empty tick, zero duration one-shot, and a zero count that leaves unfired.
        offer_item(MODE_TICK, 32'hFFFF_FFFF, 17'h1FFFF);
        offer_item(MODE_ADD_ONE, 32'h0, 17'h0);
        offer_item(MODE_TICK, 32'h0, 17'h0);
        offer_item(MODE_ADD_REP, 32'd5, 17'sd0);
        offer_item(MODE_TICK, 32'h0, 17'h0);

        // Permanent, longest count, longest period, most negative count.
        offer_item(MODE_ADD_REP, 32'd1, -17'sd1);
        offer_item(MODE_ADD_REP, 32'd2, 17'sd65535);
        offer_item(MODE_ADD_ONE, 32'hFFFF_FFFF, 17'h1FFFF);
        offer_item(MODE_ADD_REP, 32'd0, -17'sd65536);
        offer_item(MODE_TICK, 32'h0, 17'h0);
        offer_item(MODE_TICK, 32'h0, 17'h0);

        // Fill the bank, get one rejection, then a tick where most slots fire.
        repeat (12) offer_item(MODE_ADD_REP, 32'd0, 17'sd1);
        offer_item(MODE_ADD_ONE, 32'd3, 17'sd2);
        offer_item(MODE_TICK, 32'h0, 17'h0);
        offer_item(MODE_CLEAR, 32'h5A5A_A5A5, 17'h0A5A5);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            gaps_on    = ((n / 30) % 2) == 0;
            quiet_tail = (n >= RANDOM_ITEMS - 30);
            if (n == 100)
                hold_off_req = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 48)
                m = MODE_TICK;
            else if (pick < 68)
                m = MODE_ADD_ONE;
            else if (pick < 96)
                m = MODE_ADD_REP;
            else
                m = MODE_CLEAR;
            if ($urandom_range(0, 15) == 0)
                dur = $urandom();
            else
                dur = $urandom_range(0, 6);
            case ($urandom_range(0, 9))
                0:       rep = REP_W'($urandom());
                1:       rep = -17'sd1;
                default: rep = REP_W'($urandom_range(0, 4));
            endcase
            offer_item(m, dur, rep);
        end
        request_ch.valid <= 1'b0;

        @(posedge clk);
        wait (bank_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bank_fail_count == 0 && bank_pending == 0)
            $display("tb_multi_slot_software_timer_bank_core passed");
        else
            $display("tb_multi_slot_software_timer_bank_core failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/mst_pkg.sv
rtl/mst_req_if.sv
rtl/mst_rsp_if.sv
rtl/mst_ctrl.sv
rtl/mst_datapath.sv
rtl/multi_slot_software_timer_bank_core.sv
rtl/mst_checker.sv
sim/tb_timer_bank_monitor.sv
sim/tb_multi_slot_software_timer_bank_core.sv
